### rtl/rnc_pkg.sv
`default_nettype none

package rnc_pkg;

	localparam int unsigned NUM_W   = 12;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned PC_W    = 4;
	localparam int unsigned DIG_W   = 4;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned PLACE_W = 2;
	localparam int unsigned STEP_W  = 10;

	localparam logic [NUM_W-1:0] MAX_NUMBER = 12'd3999;

	localparam logic [CHAR_W-1:0] CH_I  = 7'h49;
	localparam logic [CHAR_W-1:0] CH_V  = 7'h56;
	localparam logic [CHAR_W-1:0] CH_X  = 7'h58;
	localparam logic [CHAR_W-1:0] CH_L  = 7'h4C;
	localparam logic [CHAR_W-1:0] CH_C  = 7'h43;
	localparam logic [CHAR_W-1:0] CH_D  = 7'h44;
	localparam logic [CHAR_W-1:0] CH_M  = 7'h4D;
	localparam logic [CHAR_W-1:0] CH_NL = 7'd10;

	// decimal places
	localparam logic [PLACE_W-1:0] PLACE_ONES  = 2'd0;
	localparam logic [PLACE_W-1:0] PLACE_TENS  = 2'd1;
	localparam logic [PLACE_W-1:0] PLACE_HUNDS = 2'd2;
	localparam logic [PLACE_W-1:0] PLACE_THOUS = 2'd3;

	// symbol within a place: unit, five, next unit
	localparam logic [1:0] SYM_UNIT = 2'd0;
	localparam logic [1:0] SYM_FIVE = 2'd1;
	localparam logic [1:0] SYM_NEXT = 2'd2;

	typedef enum logic [1:0] {
		OP_SUB  = 2'd0,   // repeat: take one place value off the remainder
		OP_TAKE = 2'd1,   // ones digit is what remains
		OP_EMIT = 2'd2,   // repeat: send the digit's letters
		OP_END  = 2'd3    // send newline, finish
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [PLACE_W-1:0] place;
		logic [STEP_W-1:0]  step_val;
	} ucode_t;

	typedef struct packed {
		logic [DIG_W-1:0]   digit;
		logic [IDX_W-1:0]   idx;
		logic [PLACE_W-1:0] place;
	} glyph_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] letter;
		logic              final_sym;  // last letter of this digit
	} glyph_rsp_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			4'd0:    w = '{op: OP_SUB,  place: PLACE_THOUS, step_val: 10'd1000};
			4'd1:    w = '{op: OP_EMIT, place: PLACE_THOUS, step_val: 10'd0};
			4'd2:    w = '{op: OP_SUB,  place: PLACE_HUNDS, step_val: 10'd100};
			4'd3:    w = '{op: OP_EMIT, place: PLACE_HUNDS, step_val: 10'd0};
			4'd4:    w = '{op: OP_SUB,  place: PLACE_TENS,  step_val: 10'd10};
			4'd5:    w = '{op: OP_EMIT, place: PLACE_TENS,  step_val: 10'd0};
			4'd6:    w = '{op: OP_TAKE, place: PLACE_ONES,  step_val: 10'd0};
			4'd7:    w = '{op: OP_EMIT, place: PLACE_ONES,  step_val: 10'd0};
			default: w = '{op: OP_END,  place: PLACE_ONES,  step_val: 10'd0};
		endcase
		return w;
	endfunction

	function automatic logic [IDX_W:0] shape_len(input logic [DIG_W-1:0] d);
		logic [IDX_W:0] n;
		case (d)
			4'd0:    n = 3'd0;
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			default: n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] shape_sym(input logic [DIG_W-1:0] d,
		input logic [IDX_W-1:0] i);
		logic [1:0] s;
		case (d)
			4'd4:                      s = (i == 2'd0) ? SYM_UNIT : SYM_FIVE;
			4'd5, 4'd6, 4'd7, 4'd8:    s = (i == 2'd0) ? SYM_FIVE : SYM_UNIT;
			4'd9:                      s = (i == 2'd0) ? SYM_UNIT : SYM_NEXT;
			default:                   s = SYM_UNIT;
		endcase
		return s;
	endfunction

	function automatic logic [CHAR_W-1:0] place_letter(input logic [PLACE_W-1:0] p,
		input logic [1:0] s);
		logic [CHAR_W-1:0] c;
		case (p)
			PLACE_ONES:  c = (s == SYM_UNIT) ? CH_I : (s == SYM_FIVE) ? CH_V : CH_X;
			PLACE_TENS:  c = (s == SYM_UNIT) ? CH_X : (s == SYM_FIVE) ? CH_L : CH_C;
			PLACE_HUNDS: c = (s == SYM_UNIT) ? CH_C : (s == SYM_FIVE) ? CH_D : CH_M;
			default:     c = CH_M;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/rnc_if.sv
`default_nettype none

interface rnc_num_if;
	import rnc_pkg::*;

	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

interface rnc_char_if;
	import rnc_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

### rtl/decimal_to_roman_numeral_top.sv
`default_nettype none

// Roman numeral encoder. Each number transaction (0..3999; 4000..4095 are
// treated as 3999) yields a run of ASCII letter transactions, most
// significant place first, closed by a newline (10) with last high; zero
// gives the newline alone. A small microcode table steps a plain datapath:
// for thousands, hundreds and tens it subtracts the place value once per
// cycle to count the digit, then sends that digit's letters one per cycle
// while the output can take them; the ones digit is taken from the
// remainder. One number is worked at a time; the next is taken the cycle
// after the newline step. Letters sit in an output register, so downstream
// stalls only hold the sequencer when a new letter is due.
module decimal_to_roman_numeral_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rnc_num_if.sink    numbers,
	rnc_char_if.source glyphs
);
	import rnc_pkg::*;

	// sequencer state
	logic              busy_q;
	logic [PC_W-1:0]   pc_q;
	logic [NUM_W-1:0]  rem_q;   // remainder still to convert
	logic [DIG_W-1:0]  dig_q;   // current digit
	logic [IDX_W-1:0]  idx_q;   // letter index within digit

	// output register
	logic              out_vld_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	ucode_t     cw;
	glyph_req_t g_req;
	glyph_rsp_t g_rsp;
	logic       can_emit;
	logic       take_in;
	logic       ge_step;
	logic       emit_now;   // a letter or the newline loads this cycle

	assign cw       = ucode_rom(pc_q);
	assign can_emit = !out_vld_q || glyphs.ready;
	assign take_in  = numbers.valid && !busy_q;
	assign ge_step  = rem_q >= {2'b00, cw.step_val};
	assign emit_now = busy_q && can_emit &&
		((cw.op == OP_EMIT && dig_q != '0) || cw.op == OP_END);

	assign numbers.ready    = !busy_q;
	assign glyphs.valid     = out_vld_q;
	assign glyphs.character = char_q;
	assign glyphs.last      = last_q;

	assign g_req = '{digit: dig_q, idx: idx_q, place: cw.place};

	rnc_glyph u_glyph (
		.req(g_req),
		.rsp(g_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pc_q      <= '0;
			rem_q     <= '0;
			dig_q     <= '0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
			char_q    <= '0;
			last_q    <= 1'b0;
		end else begin
			if (glyphs.ready && !emit_now)
				out_vld_q <= 1'b0;

			if (take_in) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
				dig_q  <= '0;
				idx_q  <= '0;
				rem_q  <= (numbers.number > MAX_NUMBER) ? MAX_NUMBER : numbers.number;
			end else if (busy_q) begin
				case (cw.op)
					OP_SUB: begin
						if (ge_step) begin
							rem_q <= rem_q - {2'b00, cw.step_val};
							dig_q <= dig_q + 4'd1;
						end else begin
							pc_q <= pc_q + 4'd1;
						end
					end
					OP_TAKE: begin
						dig_q <= rem_q[DIG_W-1:0];
						pc_q  <= pc_q + 4'd1;
					end
					OP_EMIT: begin
						if (dig_q == '0) begin
							pc_q <= pc_q + 4'd1;
						end else if (can_emit) begin
							out_vld_q <= 1'b1;
							char_q    <= g_rsp.letter;
							last_q    <= 1'b0;
							if (g_rsp.final_sym) begin
								pc_q  <= pc_q + 4'd1;
								dig_q <= '0;
								idx_q <= '0;
							end else begin
								idx_q <= idx_q + 2'd1;
							end
						end
					end
					OP_END: begin
						if (can_emit) begin
							out_vld_q <= 1'b1;
							char_q    <= CH_NL;
							last_q    <= 1'b1;
							busy_q    <= 1'b0;
						end
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// a run is closed only by the newline
	a_last_is_nl: assert property (@(posedge clk) disable iff (!arst_n)
		glyphs.valid && glyphs.last |-> glyphs.character == CH_NL)
		else $error("last set on a letter");

	// a taken number starts the program afresh
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		numbers.valid && numbers.ready |=> busy_q && pc_q == '0 && dig_q == '0)
		else $error("sequencer not restarted");

	// digits stay decimal
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> dig_q <= 4'd9)
		else $error("digit out of range");

	// by the ones step only the ones digit is left
	a_ones: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cw.op == OP_TAKE |-> rem_q < 12'd10)
		else $error("remainder too large at ones step");

endmodule

`default_nettype wire

### rtl/rnc_glyph.sv
`default_nettype none

// Letter lookup: digit shape, symbol slot, place letters.
module rnc_glyph (
	input  rnc_pkg::glyph_req_t req,
	output rnc_pkg::glyph_rsp_t rsp
);
	import rnc_pkg::*;

	logic [IDX_W:0] len;
	logic [1:0]     sym;

	always_comb begin
		len           = shape_len(req.digit);
		sym           = shape_sym(req.digit, req.idx);
		rsp.letter    = place_letter(req.place, sym);
		rsp.final_sym = ({1'b0, req.idx} + 3'd1) >= len;
	end
endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

// Roman numeral encoder: a run of number transactions goes in, and each
// letter transaction that comes out is checked against a predictor kept in
// step with the sender.
module tb;
	import rnc_pkg::*;

	// One letter transaction as the predictor sees it.
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} glyph_t;

	localparam int unsigned HOLD_CYCLES  = 250;   // long downstream hold-off
	localparam int unsigned DRAIN_LIMIT  = 20000; // cycles allowed to empty the queue
	localparam int unsigned TAIL_CYCLES  = 60;    // settling time after the final drain
	localparam int unsigned REPORT_LIMIT = 10;

	logic clk;
	logic arst_n;

	rnc_num_if  num_ch();
	rnc_char_if chr_ch();

	decimal_to_roman_numeral_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.numbers (num_ch),
		.glyphs  (chr_ch)
	);

	// Letters still owed by the block, oldest first.
	glyph_t pending_glyphs[$];
	int     failures;
	bit     idle_on;       // random gaps/stalls on both sides
	bit     hold_request;  // ask the receiver for one long hold-off

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Generous upper bound: ~225 numbers, each at most 16 letters, each letter
	// possibly waiting out a random receiver stall, end well before this timeout.
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void note_failure(input string what);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("[%0t] %s", $realtime, what);
	endfunction

	// Append the letters of one decimal digit, given the letters for one,
	// five and ten in that place.
	function automatic void spell_digit(input int unsigned d, input logic [CHAR_W-1:0] one,
		input logic [CHAR_W-1:0] five, input logic [CHAR_W-1:0] ten);
		if (d == 9) begin
			pending_glyphs.push_back('{one, 1'b0});
			pending_glyphs.push_back('{ten, 1'b0});
		end else if (d == 4) begin
			pending_glyphs.push_back('{one, 1'b0});
			pending_glyphs.push_back('{five, 1'b0});
		end else begin
			if (d >= 5)
				pending_glyphs.push_back('{five, 1'b0});
			repeat (d % 5)
				pending_glyphs.push_back('{one, 1'b0});
		end
	endfunction

	// Expected run for one number: places high to low, then the newline,
	// which alone carries last. Out-of-range inputs saturate.
	function automatic void spell_roman(input logic [NUM_W-1:0] n);
		int unsigned v;
		v = 32'((n > MAX_NUMBER) ? MAX_NUMBER : n);
		spell_digit(v / 1000,       CH_M, CH_M, CH_M);
		spell_digit((v / 100) % 10, CH_C, CH_D, CH_M);
		spell_digit((v / 10) % 10,  CH_X, CH_L, CH_C);
		spell_digit(v % 10,         CH_I, CH_V, CH_X);
		pending_glyphs.push_back('{CH_NL, 1'b1});
	endfunction

	// Offer one number and wait for its transaction. Valid is written once per
	// step: either lowered for a gap or left high straight into the next item.
	task automatic send_number(input logic [NUM_W-1:0] n);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			num_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		num_ch.valid  <= 1'b1;
		num_ch.number <= n;
		do
			@(posedge clk);
		while (!(num_ch.valid && num_ch.ready));
		spell_roman(n);
	endtask

	// Stop offering and wait for every owed letter, within a limit.
	task automatic drain();
		int waited;
		waited = 0;
		num_ch.valid <= 1'b0;
		while (pending_glyphs.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// Receiver: random stalls while idling is on, plus a long hold-off on
	// request, counted here so the sender can keep pushing meanwhile.
	initial begin : glyph_sink
		int stall_left;
		int hold_left;
		stall_left   = 0;
		hold_left    = 0;
		chr_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				chr_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				chr_ch.ready <= 1'b0;
			end else begin
				chr_ch.ready <= 1'b1;
				if (idle_on)
					stall_left = pick_gap();
			end
		end
	end

	// Checker: every letter transaction against the oldest expectation.
	always @(posedge clk) begin : glyph_check
		glyph_t want;
		if (arst_n && chr_ch.valid && chr_ch.ready) begin
			if (pending_glyphs.size() == 0) begin
				note_failure($sformatf("unexpected letter 0x%02h last %0b",
					chr_ch.character, chr_ch.last));
			end else begin
				want = pending_glyphs.pop_front();
				if (chr_ch.character !== want.character)
					note_failure($sformatf("character: expected 0x%02h got 0x%02h",
						want.character, chr_ch.character));
				if (chr_ch.last !== want.last)
					note_failure($sformatf("last: expected %0b got %0b",
						want.last, chr_ch.last));
			end
		end
	end

	// Edge values, a spread of digit shapes across the places, subtractive forms,
	// zero (newline only), saturation above 3999, and the longest run.
	task automatic test_directed();
		logic [NUM_W-1:0] corner[$];
		corner = {12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50, 12'd90,
			12'd100, 12'd400, 12'd500, 12'd900, 12'd1000, 12'd3000, 12'd3888,
			12'd3999, 12'd4000, 12'd4095, 12'd1994, 12'd2444, 12'd3949, 12'd2730};
		idle_on = 1'b0;
		foreach (corner[i])
			send_number(corner[i]);
		drain();
	endtask

	// Mostly legal values, a few in the saturating range; gaps and stalls on.
	task automatic test_random(input int count);
		logic [NUM_W-1:0] n;
		idle_on = 1'b1;
		repeat (count) begin
			if ($urandom_range(0, 19) == 0)
				n = NUM_W'($urandom_range(4000, 4095));
			else
				n = NUM_W'($urandom_range(0, MAX_NUMBER));
			send_number(n);
		end
	endtask

	// Receiver holds off for a long stretch while numbers keep coming, so the
	// output register fills and the input side has to stall.
	task automatic test_backpressure();
		idle_on      = 1'b0;
		hold_request = 1'b1;
		@(posedge clk);
		repeat (12)
			send_number(NUM_W'($urandom_range(0, MAX_NUMBER)));
		drain();
	endtask

	// Back-to-back numbers with no idling on either side.
	task automatic test_streaming();
		idle_on = 1'b0;
		repeat (30)
			send_number(NUM_W'($urandom_range(0, 4095)));
	endtask

	// Sender pauses until everything owed has arrived, then carries on.
	task automatic test_pause_and_resume();
		drain();
		idle_on = 1'b1;
		repeat (8)
			send_number(NUM_W'($urandom_range(0, MAX_NUMBER)));
	endtask

	initial begin
		failures      = 0;
		idle_on       = 1'b0;
		hold_request  = 1'b0;
		arst_n        = 1'b0;
		num_ch.valid  = 1'b0;
		num_ch.number = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(75);
		test_backpressure();
		test_streaming();
		test_pause_and_resume();
		test_random(75);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_glyphs.size() != 0)
			note_failure($sformatf("%0d letters never arrived", pending_glyphs.size()));

		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
